/* hw/rtl/mdhu_pkg.sv */
// shared constants, op codes and widths of the ml-dsa rounding unit
package mdhu_pkg;

    localparam int unsigned QMOD = 8380417;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned COEFF_W = 24;
    localparam int unsigned GAMMA_W = 18;
    localparam int unsigned HIGH_W  = 10;
    localparam int unsigned LOW_W   = 19;

    localparam logic [GAMMA_W-1:0] GAMMA2_RESET = 18'd261888;

    // power2round split
    localparam int unsigned P2R_D    = 13;
    localparam int unsigned P2R_HALF = 1 << (P2R_D - 1);

    // pipelined divider: reduced coefficient over 2*gamma2
    localparam int unsigned DIV_W          = 23;
    localparam int unsigned DVS_W          = GAMMA_W + 1;
    localparam int unsigned BITS_PER_STAGE = 3;
    localparam int unsigned DIV_STAGES     = (DIV_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    // transfer in to result strobe: input reg, divider, fix-up, result, output reg
    localparam int unsigned PIPE_LAT = DIV_STAGES + 5;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_P2R     = 2'd0;
    localparam t_op OP_DECOMP  = 2'd1;
    localparam t_op OP_MKHINT  = 2'd2;
    localparam t_op OP_USEHINT = 2'd3;

endpackage

/* hw/rtl/mdhu_divider.sv */
// pipelined restoring divider, BITS_PER_STAGE (3) quotient bits per stage
module mdhu_divider (
    input  logic                         i_clk,
    input  logic [mdhu_pkg::DIV_W-1:0]   i_dividend,
    input  logic [mdhu_pkg::DVS_W-1:0]   i_divisor,
    output logic [mdhu_pkg::DIV_W-1:0]   o_quotient,
    output logic [mdhu_pkg::DVS_W-1:0]   o_remainder
);

    localparam int unsigned DW = mdhu_pkg::DIV_W;
    localparam int unsigned VW = mdhu_pkg::DVS_W;
    localparam int unsigned NS = mdhu_pkg::DIV_STAGES;
    localparam int unsigned BS = mdhu_pkg::BITS_PER_STAGE;

    // upper part partial remainder, lower part dividend bits turning into quotient bits
    typedef logic [VW+DW-1:0] t_divw;

    function automatic t_divw div_step(input t_divw w, input logic [VW-1:0] d);
        logic [VW:0]   t;
        logic [DW-1:0] rest;
        t    = {w[VW+DW-1:DW], w[DW-1]};
        rest = {w[DW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            t       = t - {1'b0, d};
            rest[0] = 1'b1;
        end
        return {t[VW-1:0], rest};
    endfunction

    t_divw r_w [NS+1];

    always_ff @(posedge i_clk) begin
        r_w[0] <= {{VW{1'b0}}, i_dividend};
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        t_divw n_w;

        always_comb begin
            n_w = r_w[s];
            for (int k = 0; k < BS; k++) begin
                if (s * BS + k < DW) begin
                    n_w = div_step(n_w, i_divisor);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_w[s+1] <= n_w;
        end
    end

    assign o_quotient  = r_w[NS][DW-1:0];
    assign o_remainder = r_w[NS][VW+DW-1:DW];

endmodule

/* hw/rtl/mldsa_decompose_hint_unit_top.sv */
// ml-dsa rounding unit top: power2round, decompose, makehint, usehint
//
//  channel   strobe         payload                               dir
//  -------   ------------   -----------------------------------   ---
//  command   start / busy   i_op i_coeff i_addend i_hint_in       in
//  result    o_valid        o_high_part o_low_part o_hint_out     out
//  config    i_cfg_we       i_cfg_wdata (gamma2)                  in
//
// one command per cycle while busy is low; each result passes the input register, the
// divider by 2*gamma2 (3 quotient bits per stage), the fix-up, result and output registers.
// busy is high only for the first cycle after reset; the result side cannot
// stall, so nothing in the pipeline ever holds. reset clears valid bits and
// returns gamma2 to 261888.
module mldsa_decompose_hint_unit_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  mdhu_pkg::t_op                        i_op,
    input  logic signed [mdhu_pkg::COEFF_W-1:0]  i_coeff,
    input  logic signed [mdhu_pkg::COEFF_W-1:0]  i_addend,
    input  logic                                 i_hint_in,
    input  logic                                 i_cfg_we,
    input  logic [mdhu_pkg::GAMMA_W-1:0]         i_cfg_wdata,
    output logic                                 o_valid,
    output logic [mdhu_pkg::HIGH_W-1:0]          o_high_part,
    output logic signed [mdhu_pkg::LOW_W-1:0]    o_low_part,
    output logic                                 o_hint_out
);

    localparam int unsigned NS = mdhu_pkg::DIV_STAGES;
    localparam logic signed [26:0] QS = 27'(mdhu_pkg::QMOD);

    typedef struct packed {
        mdhu_pkg::t_op                    op;
        logic                             hint;
        logic [22:0]                      a;
        logic [22:0]                      s;
        logic [mdhu_pkg::HIGH_W-1:0]      p2r_hi;
        logic signed [mdhu_pkg::LOW_W-1:0] p2r_lo;
    } t_side;

    typedef struct packed {
        logic [22:0]        hi;
        logic signed [19:0] lo;
    } t_split;

    // bring any value in [-3q, 3q) into [0, q)
    function automatic logic [22:0] reduce_q(input logic signed [25:0] v);
        logic signed [26:0] cand;
        logic [22:0]        res;
        res = '0;
        for (int k = 0; k < 6; k++) begin
            cand = 27'(v) + 27'(k - 2) * QS;
            if (cand >= 0 && cand < QS) begin
                res = cand[22:0];
            end
        end
        return res;
    endfunction

    // center the remainder and handle the q-1 corner
    function automatic t_split split_fix(input logic [22:0] dvd, input logic [22:0] quo,
                                         input logic [18:0] rem, input logic [17:0] g);
        t_split             res;
        logic [18:0]        two;
        logic signed [19:0] r0;
        logic [22:0]        a1;
        logic [24:0]        base;
        two = {g, 1'b0};
        if (rem > {1'b0, g}) begin
            r0 = $signed({1'b0, rem}) - $signed({1'b0, two});
            a1 = quo + 23'd1;
        end else begin
            r0 = $signed({1'b0, rem});
            a1 = quo;
        end
        base = {2'b00, dvd} - 25'(r0);
        if (base == 25'(mdhu_pkg::QMOD - 1)) begin
            res.hi = '0;
            res.lo = r0 - 20'sd1;
        end else begin
            res.hi = a1;
            res.lo = r0;
        end
        return res;
    endfunction

    // input register and config
    logic                              r_busy;
    logic                              r_in_vld;
    mdhu_pkg::t_op                     r_in_op;
    logic signed [23:0]                r_in_coeff;
    logic signed [23:0]                r_in_addend;
    logic                              r_in_hint;
    logic [mdhu_pkg::GAMMA_W-1:0]      r_gamma2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_in_vld <= 1'b0;
            r_gamma2 <= mdhu_pkg::GAMMA2_RESET;
        end else begin
            r_busy   <= 1'b0;
            r_in_vld <= start && !r_busy;
            if (i_cfg_we) begin
                r_gamma2 <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_op     <= i_op;
        r_in_coeff  <= i_coeff;
        r_in_addend <= i_addend;
        r_in_hint   <= i_hint_in;
    end

    assign busy = r_busy;

    // reduction and power2round
    logic signed [25:0]           sum_cz;
    logic [22:0]                  n_a;
    logic [22:0]                  n_s;
    logic [12:0]                  p2r_t;
    t_side                        n_side;
    logic [22:0]                  dvd_b;
    logic [mdhu_pkg::DVS_W-1:0]   divisor;

    always_comb begin
        sum_cz = $signed({{2{r_in_coeff[23]}}, r_in_coeff})
               + $signed({{2{r_in_addend[23]}}, r_in_addend});
        n_a    = reduce_q($signed({{2{r_in_coeff[23]}}, r_in_coeff}));
        n_s    = reduce_q(sum_cz);
        p2r_t  = n_a[12:0];

        n_side.op   = r_in_op;
        n_side.hint = r_in_hint;
        n_side.a    = n_a;
        n_side.s    = n_s;
        if (p2r_t > 13'(mdhu_pkg::P2R_HALF)) begin
            n_side.p2r_lo = 19'(p2r_t) - 19'(1 << mdhu_pkg::P2R_D);
            n_side.p2r_hi = n_a[22:13] + 10'd1;
        end else begin
            n_side.p2r_lo = 19'(p2r_t);
            n_side.p2r_hi = n_a[22:13];
        end

        // second lane gives m = (q-1)/(2*gamma2) for usehint
        dvd_b   = (r_in_op == mdhu_pkg::OP_USEHINT) ? 23'(mdhu_pkg::QMOD - 1) : n_s;
        divisor = {r_gamma2, 1'b0};
    end

    logic [22:0]                quo_a;
    logic [22:0]                quo_b;
    logic [mdhu_pkg::DVS_W-1:0] rem_a;
    logic [mdhu_pkg::DVS_W-1:0] rem_b;

    mdhu_divider u_div_a (
        .i_clk       (i_clk),
        .i_dividend  (n_a),
        .i_divisor   (divisor),
        .o_quotient  (quo_a),
        .o_remainder (rem_a)
    );

    mdhu_divider u_div_b (
        .i_clk       (i_clk),
        .i_dividend  (dvd_b),
        .i_divisor   (divisor),
        .o_quotient  (quo_b),
        .o_remainder (rem_b)
    );

    // side data delayed alongside the dividers
    t_side       r_sd [NS+1];
    logic [NS:0] r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else begin
            r_sv <= {r_sv[NS-1:0], r_in_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= n_side;
        for (int i = 0; i < NS; i++) begin
            r_sd[i+1] <= r_sd[i];
        end
    end

    // fix-up stage
    t_split                            sp_a;
    t_split                            sp_b;
    logic                              r_f_vld;
    mdhu_pkg::t_op                     r_f_op;
    logic                              r_f_hint;
    logic                              r_f_gzero;
    logic [22:0]                       r_f_hi_a;
    logic signed [19:0]                r_f_lo_a;
    logic [22:0]                       r_f_hi_b;
    logic [22:0]                       r_f_m;
    logic [mdhu_pkg::HIGH_W-1:0]       r_f_p2r_hi;
    logic signed [mdhu_pkg::LOW_W-1:0] r_f_p2r_lo;

    always_comb begin
        sp_a = split_fix(r_sd[NS].a, quo_a, rem_a, r_gamma2);
        sp_b = split_fix(r_sd[NS].s, quo_b, rem_b, r_gamma2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_sv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_op     <= r_sd[NS].op;
        r_f_hint   <= r_sd[NS].hint;
        r_f_gzero  <= (r_gamma2 == '0);
        r_f_hi_a   <= sp_a.hi;
        r_f_lo_a   <= sp_a.lo;
        r_f_hi_b   <= sp_b.hi;
        r_f_m      <= quo_b;
        r_f_p2r_hi <= r_sd[NS].p2r_hi;
        r_f_p2r_lo <= r_sd[NS].p2r_lo;
    end

    // result stage
    logic [23:0]                       n_r_hi;
    logic signed [mdhu_pkg::LOW_W-1:0] n_r_lo;
    logic                              n_r_hint;
    logic                              n_r_mod;
    logic [23:0]                       step_v;
    logic [23:0]                       m_ext;
    logic                              r_r_vld;
    logic [23:0]                       r_r_hi;
    logic signed [mdhu_pkg::LOW_W-1:0] r_r_lo;
    logic                              r_r_hint;
    logic                              r_r_mod;
    logic [23:0]                       r_r_m;

    always_comb begin
        n_r_hi   = '0;
        n_r_lo   = '0;
        n_r_hint = 1'b0;
        n_r_mod  = 1'b0;
        m_ext    = {1'b0, r_f_m};
        step_v   = '0;
        case (r_f_op)
            mdhu_pkg::OP_P2R: begin
                n_r_hi = 24'(r_f_p2r_hi);
                n_r_lo = r_f_p2r_lo;
            end
            mdhu_pkg::OP_DECOMP: begin
                if (!r_f_gzero) begin
                    n_r_hi = {1'b0, r_f_hi_a};
                    n_r_lo = r_f_lo_a[mdhu_pkg::LOW_W-1:0];
                end
            end
            mdhu_pkg::OP_MKHINT: begin
                n_r_hint = !r_f_gzero && (r_f_hi_a != r_f_hi_b);
            end
            mdhu_pkg::OP_USEHINT: begin
                if (!r_f_gzero) begin
                    if (!r_f_hint) begin
                        n_r_hi = {1'b0, r_f_hi_a};
                    end else begin
                        // step toward the sign of the low part, wrap mod m over two stages
                        if (r_f_lo_a > 20'sd0) begin
                            step_v = {1'b0, r_f_hi_a} + 24'd1;
                        end else begin
                            step_v = {1'b0, r_f_hi_a} + m_ext - 24'd1;
                        end
                        n_r_hi  = (step_v >= m_ext) ? step_v - m_ext : step_v;
                        n_r_mod = 1'b1;
                    end
                end
            end
            default: begin
                n_r_hi = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
        end else begin
            r_r_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r_hi   <= n_r_hi;
        r_r_lo   <= n_r_lo;
        r_r_hint <= n_r_hint;
        r_r_mod  <= n_r_mod;
        r_r_m    <= m_ext;
    end

    // output register
    logic [23:0]                       n_o_hi;
    logic                              r_o_vld;
    logic [mdhu_pkg::HIGH_W-1:0]       r_o_hi;
    logic signed [mdhu_pkg::LOW_W-1:0] r_o_lo;
    logic                              r_o_hint;

    assign n_o_hi = (r_r_mod && r_r_hi >= r_r_m) ? r_r_hi - r_r_m : r_r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_hi   <= n_o_hi[mdhu_pkg::HIGH_W-1:0];
        r_o_lo   <= r_r_lo;
        r_o_hint <= r_r_hint;
    end

    assign o_valid     = r_o_vld;
    assign o_high_part = r_o_hi;
    assign o_low_part  = r_o_lo;
    assign o_hint_out  = r_o_hint;

endmodule

/* hw/rtl/mdhu_checker.sv */
// port-level checks of the rounding unit, bound to the top level
module mdhu_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_valid,
    input logic [mdhu_pkg::HIGH_W-1:0]          o_high_part,
    input logic signed [mdhu_pkg::LOW_W-1:0]    o_low_part,
    input logic                                 o_hint_out
);

    // every transfer yields exactly one result, and no result comes without a transfer
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(mdhu_pkg::PIPE_LAT) o_valid)
        else $error("result missing after command transfer");

    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, mdhu_pkg::PIPE_LAT))
        else $error("result without matching command transfer");

    // a set hint only comes from makehint, which clears both parts
    a_hint_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hint_out) |-> (o_high_part == '0 && o_low_part == '0))
        else $error("hint set with nonzero high or low part");

    // no command is taken in the cycle after reset
    a_busy_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

endmodule

bind mldsa_decompose_hint_unit_top mdhu_checker u_mdhu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_high_part (o_high_part),
    .o_low_part  (o_low_part),
    .o_hint_out  (o_hint_out)
);

/* test/testbench.sv */
// self-checking testbench for the ml-dsa rounding unit (power2round, decompose, makehint, usehint)
module testbench;

    import mdhu_pkg::*;

    localparam int     Q_INT       = int'(QMOD);
    localparam longint Q_L         = longint'(QMOD);
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     N_DIRECTED  = 25;
    localparam int     N_PHASES    = 7;
    localparam int     MAX_REPORTS = 40;

    typedef struct {
        logic [HIGH_W-1:0]        high;
        logic signed [LOW_W-1:0]  low;
        logic                     hint;
    } rounding_t;

    typedef struct {
        t_op op;
        int  coeff;
        int  addend;
        bit  hint;
        bit  typed;
        int  exp_hi;
        int  exp_lo;
        bit  exp_hint;
    } cmd_row_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    t_op                        i_op;
    logic signed [COEFF_W-1:0]  i_coeff;
    logic signed [COEFF_W-1:0]  i_addend;
    logic                       i_hint_in;
    logic                       i_cfg_we;
    logic [GAMMA_W-1:0]         i_cfg_wdata;
    logic                       o_valid;
    logic [HIGH_W-1:0]          o_high_part;
    logic signed [LOW_W-1:0]    o_low_part;
    logic                       o_hint_out;

    mldsa_decompose_hint_unit_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_coeff     (i_coeff),
        .i_addend    (i_addend),
        .i_hint_in   (i_hint_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_high_part (o_high_part),
        .o_low_part  (o_low_part),
        .o_hint_out  (o_hint_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // rows read at reset gamma2 = 261888, so m = 16
    cmd_row_t directed_cmds [N_DIRECTED] = '{
        '{OP_P2R,      0,        0,       1'b0, 1'b1, 0,    0,       1'b0},
        '{OP_P2R,      8380416,  0,       1'b0, 1'b1, 1023, 0,       1'b0},
        '{OP_P2R,      -1,       0,       1'b0, 1'b1, 1023, 0,       1'b0},
        '{OP_P2R,      4096,     0,       1'b0, 1'b1, 0,    4096,    1'b0},
        '{OP_P2R,      4097,     0,       1'b0, 1'b1, 1,    -4095,   1'b0},
        '{OP_P2R,      -8380416, 0,       1'b0, 1'b1, 0,    1,       1'b0},
        '{OP_DECOMP,   0,        0,       1'b0, 1'b1, 0,    0,       1'b0},
        '{OP_DECOMP,   261888,   0,       1'b0, 1'b1, 0,    261888,  1'b0},
        '{OP_DECOMP,   261889,   0,       1'b0, 1'b1, 1,    -261887, 1'b0},
        '{OP_DECOMP,   8380416,  0,       1'b0, 1'b1, 0,    -1,      1'b0},
        '{OP_DECOMP,   8380415,  0,       1'b0, 1'b1, 0,    -2,      1'b0},
        '{OP_DECOMP,   8118528,  0,       1'b0, 1'b1, 15,   261888,  1'b0},
        '{OP_DECOMP,   8118529,  0,       1'b0, 1'b1, 0,    -261888, 1'b0},
        '{OP_DECOMP,   -4194304, -1,      1'b1, 1'b0, 0,    0,       1'b0},
        '{OP_MKHINT,   0,        0,       1'b0, 1'b1, 0,    0,       1'b0},
        '{OP_MKHINT,   261888,   1,       1'b0, 1'b1, 0,    0,       1'b1},
        '{OP_MKHINT,   0,        -1,      1'b0, 1'b1, 0,    0,       1'b0},
        '{OP_MKHINT,   -8380416, 8380416, 1'b1, 1'b0, 0,    0,       1'b0},
        '{OP_MKHINT,   8380416,  -8380416, 1'b0, 1'b0, 0,   0,       1'b0},
        '{OP_USEHINT,  261889,   0,       1'b0, 1'b1, 1,    0,       1'b0},
        '{OP_USEHINT,  261889,   0,       1'b1, 1'b1, 0,    0,       1'b0},
        '{OP_USEHINT,  1,        0,       1'b1, 1'b1, 1,    0,       1'b0},
        '{OP_USEHINT,  0,        0,       1'b1, 1'b1, 15,   0,       1'b0},
        '{OP_USEHINT,  -1,       0,       1'b1, 1'b1, 15,   0,       1'b0},
        '{OP_USEHINT,  8118528,  0,       1'b1, 1'b1, 0,    0,       1'b0}
    };

    rounding_t   pending_results [$];
    longint      gamma2_now;
    int          mismatch_count;
    int          report_count;
    int          results_checked;
    int          hints_seen;
    int          cycle_count;
    int          op_count [4];
    int unsigned gamma_plan [N_PHASES];
    int          items_plan [N_PHASES];

    function automatic longint mod_q(longint v);
        longint r;
        r = v % Q_L;
        if (r < 0)
            r += Q_L;
        return r;
    endfunction

    // split a in [0, q) by 2*gamma2 into high part and centered low part
    function automatic void split_by_gamma(input longint a, input longint g,
                                           output longint hi, output longint lo);
        longint two, r0;
        if (g == 0) begin
            hi = 0;
            lo = 0;
            return;
        end
        two = 2 * g;
        r0 = a % two;
        if (r0 > g)
            r0 -= two;
        if (a - r0 == Q_L - 1) begin
            hi = 0;
            lo = r0 - 1;
        end else begin
            hi = (a - r0) / two;
            lo = r0;
        end
    endfunction

    function automatic rounding_t round_coeff(t_op op, int coeff, int addend, bit hint_bit,
                                              longint g);
        longint    a, s, hi, lo, h2, l2, m, p2r_mod;
        bit        differ;
        rounding_t res;
        a = mod_q(longint'(coeff));
        hi = 0;
        lo = 0;
        differ = 1'b0;
        p2r_mod = longint'(1) << P2R_D;
        case (op)
            OP_P2R: begin
                lo = a & (p2r_mod - 1);
                if (lo > longint'(P2R_HALF))
                    lo -= p2r_mod;
                hi = (a - lo) / p2r_mod;
            end
            OP_DECOMP: begin
                split_by_gamma(a, g, hi, lo);
            end
            OP_MKHINT: begin
                s = mod_q(longint'(coeff) + longint'(addend));
                if (g != 0) begin
                    split_by_gamma(a, g, hi, lo);
                    split_by_gamma(s, g, h2, l2);
                    differ = (hi != h2);
                end
                hi = 0;
                lo = 0;
            end
            default: begin
                if (g != 0) begin
                    m = (Q_L - 1) / (2 * g);
                    split_by_gamma(a, g, hi, lo);
                    if (hint_bit) begin
                        if (lo > 0)
                            hi = (hi + 1) % m;
                        else
                            hi = (hi - 1 + m) % m;
                    end
                end
                lo = 0;
            end
        endcase
        res.high = hi[HIGH_W-1:0];
        res.low  = lo[LOW_W-1:0];
        res.hint = differ;
        return res;
    endfunction

    // biased toward zero, q-1, rounding boundaries and the decompose corner
    function automatic int rand_coeff(int g);
        int v;
        int k_max;
        k_max = (g > 0) ? (Q_INT - 1) / (2 * g) : 0;
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 2 * Q_INT - 2)) - (Q_INT - 1);
            1: v = int'($urandom_range(0, 600)) - 300;
            2: v = int'($urandom_range(0, k_max)) * 2 * g + g + int'($urandom_range(0, 6)) - 3;
            default: v = Q_INT - 1 - int'($urandom_range(0, g + 2));
        endcase
        if (v > Q_INT - 1)
            v = Q_INT - 1 - int'($urandom_range(0, 3));
        if (v < 0 && v < -(Q_INT - 1))
            v = -(Q_INT - 1);
        if (v > 0 && $urandom_range(0, 1) == 1)
            v -= Q_INT;
        return v;
    endfunction

    task automatic send_cmd(t_op op, int coeff, int addend, bit hint_bit, rounding_t exp_res,
                            int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_op      <= op;
        i_coeff   <= coeff[COEFF_W-1:0];
        i_addend  <= addend[COEFF_W-1:0];
        i_hint_in <= hint_bit;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_results.push_back(exp_res);
        op_count[op]++;
    endtask

    // hold commands off until every transfer in flight has come back
    task automatic settle_pipeline();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_gamma2(int unsigned value);
        settle_pipeline();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[GAMMA_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gamma2_now = longint'(value);
    endtask

    task automatic flag_field(string field, int exp_v, int got_v);
        mismatch_count++;
        if (report_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
        report_count++;
    endtask

    always @(posedge i_clk) begin
        rounding_t exp_res;
        if (i_rst_n && o_valid) begin
            results_checked++;
            if (o_hint_out)
                hints_seen++;
            if (pending_results.size() == 0) begin
                flag_field("unexpected result, high_part", 0, int'(o_high_part));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_high_part !== exp_res.high)
                    flag_field("high_part", int'(exp_res.high), int'(o_high_part));
                if (o_low_part !== exp_res.low)
                    flag_field("low_part", int'(exp_res.low), int'(o_low_part));
                if (o_hint_out !== exp_res.hint)
                    flag_field("hint_out", int'(exp_res.hint), int'(o_hint_out));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        cmd_row_t  row;
        rounding_t exp_res;
        t_op       op;
        int        coeff;
        int        addend;
        int        span;
        bit        hint_bit;
        bit        idle_on;
        int        gap;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = OP_P2R;
        i_coeff     = '0;
        i_addend    = '0;
        i_hint_in   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        gamma2_now  = longint'(GAMMA2_RESET);
        mismatch_count  = 0;
        report_count    = 0;
        results_checked = 0;
        hints_seen      = 0;
        cycle_count     = 0;
        op_count        = '{0, 0, 0, 0};

        // the low end of the range, zero, a small value that overflows the high part,
        // random settings in range, then back to the reset value (the high end)
        gamma_plan = '{95232, 0, 1000, 0, 0, 0, 261888};
        items_plan = '{300, 40, 60, 250, 250, 250, 250};
        for (int p = 3; p < 6; p++)
            gamma_plan[p] = $urandom_range(95232, 261888);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_cmds[i];
            if (row.typed) begin
                exp_res.high = row.exp_hi[HIGH_W-1:0];
                exp_res.low  = row.exp_lo[LOW_W-1:0];
                exp_res.hint = row.exp_hint;
            end else begin
                exp_res = round_coeff(row.op, row.coeff, row.addend, row.hint, gamma2_now);
            end
            send_cmd(row.op, row.coeff, row.addend, row.hint, exp_res, $urandom_range(0, 14));
        end

        idle_on = 1'b1;
        for (int p = 0; p < N_PHASES; p++) begin
            write_gamma2(gamma_plan[p]);
            for (int i = 0; i < items_plan[p]; i++) begin
                if (i % 50 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                if (p == 0 && i == 150)
                    settle_pipeline();
                op = t_op'($urandom_range(0, 3));
                coeff = rand_coeff(int'(gamma2_now));
                if (op == OP_MKHINT && $urandom_range(0, 1) == 1) begin
                    span = (gamma2_now > 300) ? int'(gamma2_now + gamma2_now / 2) : 300;
                    addend = int'($urandom_range(0, 2 * span)) - span;
                end else begin
                    addend = int'($urandom_range(0, 2 * Q_INT - 2)) - (Q_INT - 1);
                end
                hint_bit = $urandom_range(0, 1);
                exp_res = round_coeff(op, coeff, addend, hint_bit, gamma2_now);
                gap = idle_on ? $urandom_range(0, 14) : 0;
                send_cmd(op, coeff, addend, hint_bit, exp_res, gap);
            end
        end

        settle_pipeline();
        repeat (PIPE_LAT + 5) @(negedge i_clk);

        $display("%0d commands (p2r %0d, decompose %0d, makehint %0d, usehint %0d), %0d gamma2 settings",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[0],
                 op_count[1], op_count[2], op_count[3], N_PHASES + 1);
        $display("%0d results checked, %0d with hint set, %0d field mismatches",
                 results_checked, hints_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
